// ===== rtl/core/pbs_pkg.sv =====
// Shared types and constants for the pixel background subtractor.
`timescale 1ns / 1ps

package pbs_pkg;

    // Frame size default and field widths
    localparam int DEFAULT_PIXEL_COUNT = 65536;
    localparam int INDEX_W             = 16;
    localparam int COLOR_W             = 24;
    localparam int DIST_W              = 18;
    localparam int COUNT_W             = 8;
    localparam int WEIGHT_W            = 9;

    // APB register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_DIST_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_DURATION_LIMIT = 2'd1;
    localparam logic [1:0] REG_NEW_WEIGHT     = 2'd2;

    localparam logic [DIST_W-1:0]   RST_DIST_THRESHOLD = 18'd900;
    localparam logic [COUNT_W-1:0]  RST_DURATION_LIMIT = 8'd10;
    localparam logic [WEIGHT_W-1:0] RST_NEW_WEIGHT     = 9'd243;

    // Request kinds carried on s_tuser
    localparam logic FUNC_INIT   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Configuration handed from the register block to the datapath
    typedef struct packed {
        logic [DIST_W-1:0]   dist_threshold;
        logic [COUNT_W-1:0]  duration_limit;
        logic [WEIGHT_W-1:0] new_weight;
    } cfg_t;

endpackage

// ===== rtl/core/pbs_cfg_regs.sv =====
// APB configuration registers for the pixel background subtractor.
`timescale 1ns / 1ps

module pbs_cfg_regs
    import pbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register writes; addresses past the map are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_threshold <= RST_DIST_THRESHOLD;
            cfg_reg.duration_limit <= RST_DURATION_LIMIT;
            cfg_reg.new_weight     <= RST_NEW_WEIGHT;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DIST_THRESHOLD: cfg_reg.dist_threshold <= pwdata[DIST_W-1:0];
                REG_DURATION_LIMIT: cfg_reg.duration_limit <= pwdata[COUNT_W-1:0];
                REG_NEW_WEIGHT:     cfg_reg.new_weight     <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_sel)
            REG_DIST_THRESHOLD: prdata = APB_DATA_W'(cfg_reg.dist_threshold);
            REG_DURATION_LIMIT: prdata = APB_DATA_W'(cfg_reg.duration_limit);
            REG_NEW_WEIGHT:     prdata = APB_DATA_W'(cfg_reg.new_weight);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/pixel_background_subtractor_unit.sv =====
// Top level of the pixel background subtractor: stream pipeline around the pixel memory.
`timescale 1ns / 1ps
//
// Per-pixel motion detector with a running-average background.
// Input stream (s_*): one request per pixel. s_tuser is the kind (0 = init the
// background and clear the motion count, 1 = update and classify), s_tdata
// carries the pixel index and its colour. Output stream (m_*): one result per
// request, giving the pixel position and the moving flag.
// Configuration goes through the APB port: threshold at 0x0, duration limit
// at 0x4, blend weight at 0x8. Write it only while the block is idle.
// A request goes from the memory read to stage 1, stage 2 and the output queue.
// Throughput: one request per cycle. A request for the same pixel as the one
// held in stage 1 waits until that one moves on, since the pixel memory
// read-modify-write loop spans two stages; the memory write and a read in
// the same cycle meet through a forwarding register.
// A two-entry output queue separates the sides: requests keep flowing while
// a result waits; a stall that fills the queue holds the whole pipeline.
// Reset clears the pipeline, the queue and the registers. The pixel memory is
// not cleared; each pixel needs an init request before its first update.
// Pixel indexes at or above PIXEL_COUNT leave the memory alone and report a moving flag of 0.

module pixel_background_subtractor_unit
    import pbs_pkg::*;
#(
    parameter int PIXEL_COUNT = DEFAULT_PIXEL_COUNT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // [15:0] pixel_index, [39:16] pixel_color
    input  logic                  s_tuser,   // [0] func
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [15:0] pixel_position
    output logic                  m_tuser,   // [0] is_moving
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int WORD_W = COUNT_W + COLOR_W;

    cfg_t cfg;

    pbs_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Per-channel blend, rounded; result fits 8 bits for w up to 256
    function automatic logic [7:0] blend_chan(input logic [7:0] nv, input logic [7:0] ov,
                                              input logic [WEIGHT_W-1:0] w);
        logic [16:0] pn;
        logic [16:0] po;
        logic [17:0] s;
        pn = 17'(nv) * 17'(w);
        po = 17'(ov) * 17'(9'd256 - w);
        s  = 18'(pn) + 18'(po) + 18'd128;
        return s[15:8];
    endfunction

    // Pixel memory word: motion count on top, background colour below
    logic [WORD_W-1:0] pix_mem [PIXEL_COUNT];

    // Input decode
    logic [INDEX_W-1:0] in_idx;
    logic [COLOR_W-1:0] in_color;
    logic [31:0]        in_idx_ext;
    logic [ADDR_W-1:0]  in_addr;
    logic               in_inr;
    logic               in_acc;
    logic               hazard;
    logic               adv;

    assign in_idx     = s_tdata[15:0];
    assign in_color   = s_tdata[39:16];
    assign in_idx_ext = 32'(in_idx);
    assign in_addr    = in_idx_ext[ADDR_W-1:0];
    assign in_inr     = (in_idx_ext < 32'(PIXEL_COUNT));

    // Stage 1 and 2 registers
    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic               s1_inr_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [WORD_W-1:0]  rdata_reg;

    logic               s2_valid_reg;
    logic               s2_func_reg;
    logic [INDEX_W-1:0] s2_idx_reg;
    logic [COLOR_W-1:0] s2_color_reg;
    logic               s2_inr_reg;
    logic [ADDR_W-1:0]  s2_addr_reg;
    logic [DIST_W-1:0]  s2_dist_reg;
    logic [WORD_W-1:0]  s2_old_reg;

    // Last write, seen by the read issued in the same cycle
    logic               lw_valid_reg;
    logic [ADDR_W-1:0]  lw_addr_reg;
    logic [WORD_W-1:0]  lw_data_reg;

    // Output queue
    logic [INDEX_W-1:0] q_pos_reg [2];
    logic               q_mov_reg [2];
    logic               q_wptr_reg;
    logic               q_rptr_reg;
    logic [1:0]         q_count_reg;
    logic [1:0]         q_count_next;
    logic               q_push;
    logic               q_pop;

    // Flow control: pipeline moves while the queue has room
    assign adv      = ~q_count_reg[1];
    assign hazard   = s1_valid_reg && s1_inr_reg && in_inr && (s1_addr_reg == in_addr);
    assign s_tready = adv && !hazard;
    assign in_acc   = s_tvalid && s_tready;

    // Memory read at accept
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            rdata_reg <= pix_mem[in_addr];
        end
    end

    // Stage 1: forward the concurrent write, then squared distance
    logic [WORD_W-1:0] s1_old;
    logic [15:0]       sq [3];
    logic [DIST_W-1:0] s1_dist;

    always_comb begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        s1_old = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : rdata_reg;
        for (int c = 0; c < 3; c++) begin
            a     = s1_old[8*c +: 8];
            b     = s1_color_reg[8*c +: 8];
            d     = (a > b) ? (a - b) : (b - a);
            sq[c] = 16'(d) * 16'(d);
        end
        s1_dist = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
    end

    // Stage 2: classify, advance the count, blend, write back (init writes the colour with a cleared count)
    logic                is_moving;
    logic                over;
    logic [COUNT_W-1:0]  old_cnt;
    logic [COUNT_W-1:0]  cnt_next;
    logic                adapt;
    logic [WEIGHT_W-1:0] w_sat;
    logic [COLOR_W-1:0]  bg_blend;
    logic [COLOR_W-1:0]  bg_next;
    logic [WORD_W-1:0]   wr_data;
    logic                wr_en;

    assign over    = s2_dist_reg > cfg.dist_threshold;
    assign old_cnt = s2_old_reg[WORD_W-1:COLOR_W];
    assign w_sat   = (cfg.new_weight > 9'd256) ? 9'd256 : cfg.new_weight;

    always_comb begin
        if (over) begin
            cnt_next = (old_cnt == 8'hFF) ? old_cnt : old_cnt + 8'd1;
        end else begin
            cnt_next = '0;
        end
        adapt = cnt_next > cfg.duration_limit;
        for (int c = 0; c < 3; c++) begin
            bg_blend[8*c +: 8] = blend_chan(s2_color_reg[8*c +: 8], s2_old_reg[8*c +: 8],
                                            w_sat);
        end
        bg_next = adapt ? bg_blend : s2_old_reg[COLOR_W-1:0];
        if (s2_func_reg == FUNC_INIT) begin
            wr_data = {{COUNT_W{1'b0}}, s2_color_reg};
        end else begin
            wr_data = {cnt_next, bg_next};
        end
    end

    assign is_moving = (s2_func_reg == FUNC_UPDATE) && s2_inr_reg && over;
    assign wr_en     = adv && s2_valid_reg && s2_inr_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pix_mem[s2_addr_reg] <= wr_data;
        end
    end

    // Pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            lw_valid_reg <= wr_en;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_func_reg  <= s_tuser;
            s1_idx_reg   <= in_idx;
            s1_color_reg <= in_color;
            s1_inr_reg   <= in_inr;
            s1_addr_reg  <= in_addr;
        end
        if (adv) begin
            s2_func_reg  <= s1_func_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_color_reg <= s1_color_reg;
            s2_inr_reg   <= s1_inr_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_dist_reg  <= s1_dist;
            s2_old_reg   <= s1_old;
            lw_addr_reg  <= s2_addr_reg;
            lw_data_reg  <= wr_data;
        end
    end

    // Output queue
    assign q_push       = adv && s2_valid_reg;
    assign q_pop        = m_tvalid && m_tready;
    assign q_count_next = q_count_reg + {1'b0, q_push} - {1'b0, q_pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wptr_reg  <= 1'b0;
            q_rptr_reg  <= 1'b0;
            q_count_reg <= '0;
        end else begin
            if (q_push) begin
                q_wptr_reg <= ~q_wptr_reg;
            end
            if (q_pop) begin
                q_rptr_reg <= ~q_rptr_reg;
            end
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push) begin
            q_pos_reg[q_wptr_reg] <= s2_idx_reg;
            q_mov_reg[q_wptr_reg] <= is_moving;
        end
    end

    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tdata  = q_pos_reg[q_rptr_reg];
    assign m_tuser  = q_mov_reg[q_rptr_reg];

endmodule
